/* hw/rtl/sspp_pkg.sv */
// Shared types, constants and the CRC step for the servo status packet parser.
package sspp_pkg;

    localparam int PARAM_DEPTH = 32;
    localparam int PIDX_W      = $clog2(PARAM_DEPTH);
    localparam int RAM_DEPTH   = 2 * PARAM_DEPTH;
    localparam int RAM_AW      = $clog2(RAM_DEPTH);
    localparam int MAX_LIMIT   = (PARAM_DEPTH < 32) ? PARAM_DEPTH : 32;

    localparam logic [7:0]  HDR_SYNC   = 8'hFF;
    localparam logic [7:0]  HDR_LAST   = 8'hFD;
    localparam logic [7:0]  INSTR_STAT = 8'h55;
    localparam logic [15:0] CRC_POLY   = 16'h8005;
    localparam logic [8:0]  POS_MAX    = 9'd511;
    localparam logic [8:0]  POS_PARAM  = 9'd9;
    localparam logic [9:0]  PKT_MIN    = 10'd11;
    localparam logic [9:0]  PKT_MAX    = 10'd255;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_HDR  = 3'd1;
    localparam logic [2:0] ST_BAD_CRC  = 3'd2;
    localparam logic [2:0] ST_NOT_STAT = 3'd3;
    localparam logic [2:0] ST_TOO_MANY = 3'd4;
    localparam logic [2:0] ST_BAD_SIZE = 3'd5;

    localparam logic KIND_PARAM  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // One judged packet, handed from front to back.
    typedef struct packed {
        logic [2:0] code;
        logic [7:0] cnt;
        logic [7:0] id;
        logic [7:0] err;
        logic [7:0] len;    // bytes received, low 8 bits
        logic       bank;
    } t_job;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PARAM,
        S_STATUS
    } t_back_state;

    // CRC-16/0x8005, MSB first, one byte.
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) c = {c[14:0], 1'b0} ^ CRC_POLY;
            else       c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

/* hw/rtl/sspp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module sspp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* hw/rtl/sspp_front.sv */
// Front end: takes packet bytes, tracks header/CRC/fields, stores params, judges the packet.
module sspp_front import sspp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    input  logic [5:0]        i_max_params,
    output logic              o_push,
    output t_job              o_job,
    input  logic              i_done,
    output logic              o_we,
    output logic [RAM_AW-1:0] o_waddr,
    output logic [7:0]        o_wdata
);
    logic [8:0]  r_pos;
    logic [15:0] r_crc;
    logic [7:0]  r_lag0, r_lag1;
    logic        r_hdr_ok;
    logic [7:0]  r_id, r_err, r_instr;
    logic [15:0] r_len;
    logic        r_bank;
    logic [1:0]  r_pending;   // judged packets not yet retired by the back end

    logic        acc;
    logic [15:0] n_crc, rx_crc;
    logic        n_hdr_ok;
    logic [7:0]  n_id, n_err, n_instr;
    logic [15:0] n_len;
    logic [8:0]  pos_off;
    logic [9:0]  n_bytes;
    logic [7:0]  cnt;
    logic [5:0]  limit;
    logic [2:0]  code;

    // both banks busy when two packets are pending
    assign o_ready = ~r_pending[1];
    assign acc     = i_valid & o_ready;

    always_comb begin
        n_crc    = (r_pos >= 9'd2) ? crc_fold(r_crc, r_lag0) : r_crc;
        n_hdr_ok = r_hdr_ok;
        if ((r_pos == 9'd0 || r_pos == 9'd1) && i_byte != HDR_SYNC) n_hdr_ok = 1'b0;
        if (r_pos == 9'd2 && i_byte != HDR_LAST) n_hdr_ok = 1'b0;
        n_id    = (r_pos == 9'd4) ? i_byte : r_id;
        n_len   = r_len;
        if (r_pos == 9'd5) n_len[7:0]  = i_byte;
        if (r_pos == 9'd6) n_len[15:8] = i_byte;
        n_instr = (r_pos == 9'd7) ? i_byte : r_instr;
        n_err   = (r_pos == 9'd8) ? i_byte : r_err;
        rx_crc  = {i_byte, r_lag1};
    end

    always_comb begin
        n_bytes = {1'b0, r_pos} + 10'd1;
        cnt     = n_len[7:0] - 8'd4;
        limit   = (i_max_params > 6'(MAX_LIMIT)) ? 6'(MAX_LIMIT) : i_max_params;
        priority if (n_bytes < PKT_MIN || n_bytes > PKT_MAX) code = ST_BAD_SIZE;
        else if (!n_hdr_ok)                                  code = ST_BAD_HDR;
        else if (rx_crc != n_crc)                            code = ST_BAD_CRC;
        else if (n_instr != INSTR_STAT)                      code = ST_NOT_STAT;
        else if (cnt > {2'b00, limit})                       code = ST_TOO_MANY;
        else                                                 code = ST_OK;
    end

    assign o_push     = acc & i_last;
    assign o_job.code = code;
    assign o_job.cnt  = cnt;
    assign o_job.id   = n_id;
    assign o_job.err  = n_err;
    assign o_job.len  = n_bytes[7:0];
    assign o_job.bank = r_bank;

    // parameter bytes go to this packet's bank
    assign pos_off = r_pos - POS_PARAM;
    assign o_we    = acc && r_pos >= POS_PARAM && pos_off < 9'(PARAM_DEPTH);
    assign o_waddr = {r_bank, pos_off[PIDX_W-1:0]};
    assign o_wdata = i_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_crc    <= '0;
            r_lag0   <= '0;
            r_lag1   <= '0;
            r_hdr_ok <= 1'b1;
            r_id     <= '0;
            r_err    <= '0;
            r_instr  <= '0;
            r_len    <= '0;
            r_bank   <= 1'b0;
        end else if (acc) begin
            if (i_last) begin
                r_pos    <= '0;
                r_crc    <= '0;
                r_lag0   <= '0;
                r_lag1   <= '0;
                r_hdr_ok <= 1'b1;
                r_id     <= '0;
                r_err    <= '0;
                r_instr  <= '0;
                r_len    <= '0;
                r_bank   <= ~r_bank;
            end else begin
                r_pos    <= (r_pos < POS_MAX) ? r_pos + 9'd1 : POS_MAX;
                r_crc    <= n_crc;
                r_lag0   <= r_lag1;
                r_lag1   <= i_byte;
                r_hdr_ok <= n_hdr_ok;
                r_id     <= n_id;
                r_err    <= n_err;
                r_instr  <= n_instr;
                r_len    <= n_len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_pending <= '0;
        else if (o_push && !i_done) r_pending <= r_pending + 2'd1;
        else if (!o_push && i_done) r_pending <= r_pending - 2'd1;
    end
endmodule

/* hw/rtl/sspp_queue.sv */
// Two-entry job queue between front and back.
module sspp_queue import sspp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_job o_job
);
    t_job       r_slot [2];
    logic       r_wp, r_rp;
    logic [1:0] r_count;
    logic       do_push, do_pop;

    assign o_full  = r_count[1];
    assign o_valid = (r_count != 2'd0);
    assign o_job   = r_slot[r_rp];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) r_slot[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= '0;
        end else begin
            if (do_push) r_wp <= ~r_wp;
            if (do_pop)  r_rp <= ~r_rp;
            if (do_push && !do_pop)      r_count <= r_count + 2'd1;
            else if (!do_push && do_pop) r_count <= r_count - 2'd1;
        end
    end
endmodule

/* hw/rtl/sspp_back.sv */
// Back end: replays stored parameters of a good packet, then the status result.
module sspp_back import sspp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  t_job              i_job,
    output logic              o_pop,
    output logic              o_done,
    output logic [RAM_AW-1:0] o_raddr,
    input  logic [7:0]        i_rdata,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_kind,
    output logic [7:0]        o_param_byte,
    output logic [4:0]        o_param_index,
    output logic [2:0]        o_status_code,
    output logic [7:0]        o_device_id,
    output logic [7:0]        o_device_error,
    output logic [7:0]        o_param_count,
    output logic              o_run_end
);
    t_back_state r_state, n_state;
    t_job        r_job;
    logic [5:0]  r_idx;
    logic        r_primed;    // read data matches r_idx
    logic        r_valid;

    logic        out_free, ld_param, ld_status, last_param, good;
    logic [7:0]  pbyte;

    assign out_free   = ~r_valid | i_ready;
    assign last_param = (r_idx + 6'd1) == r_job.cnt[5:0];
    assign good       = (i_job.code == ST_OK) && (i_job.cnt != 8'd0);
    assign o_raddr    = {r_job.bank, r_idx[PIDX_W-1:0]};
    assign pbyte      = (({2'b00, r_idx} + 8'd9) < r_job.len) ? i_rdata : 8'd0;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_q_valid) n_state = good ? S_PARAM : S_STATUS;
            S_PARAM:  if (ld_param && last_param) n_state = S_STATUS;
            S_STATUS: if (ld_status) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_pop     = 1'b0;
        ld_param  = 1'b0;
        ld_status = 1'b0;
        unique case (r_state)
            S_IDLE:   o_pop     = i_q_valid;
            S_PARAM:  ld_param  = r_primed & out_free;
            S_STATUS: ld_status = out_free;
            default:  ;
        endcase
    end

    assign o_done = ld_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_idx    <= '0;
            r_primed <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_idx    <= '0;
                r_primed <= 1'b0;
            end else if (ld_param) begin
                r_idx    <= r_idx + 6'd1;
                r_primed <= 1'b0;
            end else begin
                r_primed <= 1'b1;
            end
            if (ld_param || ld_status) r_valid <= 1'b1;
            else if (i_ready)          r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_job <= i_job;
        if (ld_param) begin
            o_kind         <= KIND_PARAM;
            o_param_byte   <= pbyte;
            o_param_index  <= r_idx[4:0];
            o_status_code  <= ST_OK;
            o_device_id    <= '0;
            o_device_error <= '0;
            o_param_count  <= '0;
            o_run_end      <= 1'b0;
        end else if (ld_status) begin
            o_kind        <= KIND_STATUS;
            o_param_byte  <= '0;
            o_param_index <= '0;
            o_status_code <= r_job.code;
            o_run_end     <= 1'b1;
            if (r_job.code == ST_OK || r_job.code == ST_TOO_MANY) begin
                o_device_id    <= r_job.id;
                o_device_error <= r_job.err;
                o_param_count  <= r_job.cnt;
            end else begin
                o_device_id    <= '0;
                o_device_error <= '0;
                o_param_count  <= '0;
            end
        end
    end

    assign o_valid = r_valid;
endmodule

/* hw/rtl/servo_status_packet_parser.sv */
// Top level of the servo status packet parser: config register and front/queue/back wiring.
//
// Input stream: one packet byte per transfer on i_s_tdata, i_s_tlast on the final byte.
// Output stream: per good packet, one transfer per parameter (tuser = 0), then one
// status transfer (tuser = 1, tlast = 1). Bad packets give only the status transfer.
// The front end judges header, CRC-16/0x8005, instruction, size and parameter count
// as bytes arrive, one byte per cycle while not stalled, and writes parameter bytes into one bank of a
// two-bank parameter RAM. On the last byte the judged packet enters a two-entry queue.
// The back end replays parameters from the RAM through a registered RAM read, then the
// output register, and starts each parameter's read only after the previous one is loaded;
// with no parameters the status passes through the queue, the job register and the output register.
// Input stalls (tready low) only while two judged packets are still being drained,
// since both RAM banks are then in use; otherwise bytes flow at one per cycle.
// A receiver stall just holds the output register; the back end waits behind it.
// Reset (synchronous, active low) empties queue and pipeline, clears packet state
// and sets max_params to 32. APB register 0 (address 0): max_params, 6 bits.
module servo_status_packet_parser import sspp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // packet byte stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,     // [7:0] rx_byte
    input  logic        i_s_tlast,     // last_byte
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [7:0] param_byte, [12:8] param_index, [15:13] status_code,
    // [23:16] device_id, [31:24] device_error, [39:32] param_count
    output logic [39:0] o_m_tdata,
    output logic        o_m_tuser,     // [0] result_kind
    output logic        o_m_tlast,     // run_end
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [5:0]        r_max_params;
    logic              push, pop, done, q_full, q_valid;
    t_job              f_job, q_job;
    logic              we;
    logic [RAM_AW-1:0] waddr, raddr;
    logic [7:0]        wdata, rdata;
    logic              f_ready;

    assign pready = 1'b1;
    assign prdata = {26'd0, r_max_params};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_max_params <= 6'd32;
        else if (psel && penable && pwrite && pready && paddr == 1'b0)
            r_max_params <= pwdata[5:0];
    end

    sspp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_tvalid),
        .o_ready      (f_ready),
        .i_byte       (i_s_tdata),
        .i_last       (i_s_tlast),
        .i_max_params (r_max_params),
        .o_push       (push),
        .o_job        (f_job),
        .i_done       (done),
        .o_we         (we),
        .o_waddr      (waddr),
        .o_wdata      (wdata)
    );

    // pending count in the front already keeps the queue from overflowing
    assign o_s_tready = f_ready;

    sspp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (f_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_job   (q_job)
    );

    sspp_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    sspp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid & ~(q_full & 1'b0)),
        .i_job          (q_job),
        .o_pop          (pop),
        .o_done         (done),
        .o_raddr        (raddr),
        .i_rdata        (rdata),
        .o_valid        (o_m_tvalid),
        .i_ready        (i_m_tready),
        .o_kind         (o_m_tuser),
        .o_param_byte   (o_m_tdata[7:0]),
        .o_param_index  (o_m_tdata[12:8]),
        .o_status_code  (o_m_tdata[15:13]),
        .o_device_id    (o_m_tdata[23:16]),
        .o_device_error (o_m_tdata[31:24]),
        .o_param_count  (o_m_tdata[39:32]),
        .o_run_end      (o_m_tlast)
    );
endmodule

/* bench/tb_servo_status_packet_parser.sv */
// Testbench for servo_status_packet_parser: random and directed status packets, scoreboard check.
module tb_servo_status_packet_parser;
    import sspp_pkg::*;

    // Clock, reset and the limits of the run.
    localparam int  WATCHDOG_LIMIT = 4000;  // idle cycles allowed; longer than the HOLD_CYCLES hold-off
    localparam int  HOLD_CYCLES    = 400;   // long receiver hold-off for the pressure test
    localparam int  DRAIN_CYCLES   = 12;    // quiet cycles after the last expected result
    localparam int  RANDOM_BYTES   = 330;   // bytes of random traffic
    localparam int  MAX_PRINTS     = 60;
    localparam logic REG_MAX_PARAMS = 1'b0; // APB byte address 0

    // One result transfer, as the predictor expects it.
    typedef struct packed {
        logic       kind;
        logic [7:0] pbyte;
        logic [4:0] pidx;
        logic [2:0] code;
        logic [7:0] id;
        logic [7:0] err;
        logic [7:0] cnt;
        logic       run_end;
    } t_result;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tready = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic        paddr    = 1'b0;
    logic [31:0] pwdata   = 32'h0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [39:0] o_m_tdata;
    logic        o_m_tuser;
    logic        o_m_tlast;
    logic [31:0] prdata;
    logic        pready;

    servo_status_packet_parser dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),     // [7:0] rx_byte
        .i_s_tlast  (s_tlast),     // last_byte
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        // [7:0] param_byte, [12:8] param_index, [15:13] status_code,
        // [23:16] device_id, [31:24] device_error, [39:32] param_count
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),   // [0] result_kind
        .o_m_tlast  (o_m_tlast),   // run_end
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: parser position, running CRC, two-byte lag for the
    // trailing CRC, captured header fields and the parameter buffer.
    // ------------------------------------------------------------------
    logic [8:0]  rx_pos;
    logic [15:0] crc_acc;
    logic [7:0]  trail [2];
    logic        hdr_ok;
    logic [7:0]  pkt_id;
    logic [7:0]  pkt_err;
    logic [7:0]  pkt_instr;
    logic [15:0] len_word;
    logic [7:0]  pbuf [PARAM_DEPTH];
    logic [5:0]  max_params_cfg;

    t_result     pending_results [$];
    logic [7:0]  pkt_bytes [$];     // packet under construction
    int          mismatches  = 0;
    int          bytes_sent  = 0;
    int          burst_left  = 0;
    bit          sender_gaps = 1'b1;
    bit          hold_on     = 1'b0;
    event        start_hold;

    // CRC-16/0x8005, MSB first, one data bit at a time.
    function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] d);
        logic [15:0] r;
        logic        fb;
        r = acc;
        for (int i = 7; i >= 0; i--) begin
            fb = r[15] ^ d[i];
            r  = {r[14:0], 1'b0};
            if (fb) r = r ^ CRC_POLY;
        end
        return r;
    endfunction

    function automatic void clear_packet_state();
        rx_pos    = '0;
        crc_acc   = '0;
        trail[0]  = '0;
        trail[1]  = '0;
        hdr_ok    = 1'b1;
        pkt_id    = '0;
        pkt_err   = '0;
        pkt_instr = '0;
        len_word  = '0;
    endfunction

    // Folds one accepted byte into the parser state; on the last byte it
    // judges the packet and queues the parameter and status results.
    function automatic void absorb_byte(input logic [7:0] b, input logic last);
        logic [8:0]  p;
        logic [9:0]  n;
        logic [15:0] rx_crc;
        logic [7:0]  cnt;
        logic [2:0]  code;
        int          lim;
        t_result     r;
        p = rx_pos;
        // CRC runs two bytes behind so the trailing CRC itself is left out
        if (p >= 2) crc_acc = crc16_step(crc_acc, trail[0]);
        if (p <= 1 && b != HDR_SYNC) hdr_ok = 1'b0;
        if (p == 2 && b != HDR_LAST) hdr_ok = 1'b0;
        if (p == 4) pkt_id = b;
        if (p == 5) len_word[7:0] = b;
        if (p == 6) len_word[15:8] = b;
        if (p == 7) pkt_instr = b;
        if (p == 8) pkt_err = b;
        if (p >= POS_PARAM && int'(p) - int'(POS_PARAM) < PARAM_DEPTH)
            pbuf[int'(p) - int'(POS_PARAM)] = b;
        rx_crc   = {b, trail[1]};
        trail[0] = trail[1];
        trail[1] = b;
        if (!last) begin
            if (p != POS_MAX) rx_pos = p + 9'd1;
            return;
        end

        n   = {1'b0, p} + 10'd1;
        cnt = len_word[7:0] - 8'd4;
        lim = (int'(max_params_cfg) > MAX_LIMIT) ? MAX_LIMIT : int'(max_params_cfg);
        // size beats header beats CRC beats instruction beats count
        if (n < PKT_MIN || n > PKT_MAX)   code = ST_BAD_SIZE;
        else if (!hdr_ok)                 code = ST_BAD_HDR;
        else if (rx_crc != crc_acc)       code = ST_BAD_CRC;
        else if (pkt_instr != INSTR_STAT) code = ST_NOT_STAT;
        else if (int'(cnt) > lim)         code = ST_TOO_MANY;
        else                              code = ST_OK;

        if (code == ST_OK) begin
            for (int i = 0; i < int'(cnt); i++) begin
                r = '0;
                r.kind = KIND_PARAM;
                r.pidx = i[4:0];
                // positions past the received bytes read as zero
                r.pbyte = (i + int'(POS_PARAM) < int'(n)) ? pbuf[i] : 8'h00;
                pending_results.push_back(r);
            end
        end
        r = '0;
        r.kind    = KIND_STATUS;
        r.code    = code;
        r.run_end = 1'b1;
        if (code == ST_OK || code == ST_TOO_MANY) begin
            r.id  = pkt_id;
            r.err = pkt_err;
            r.cnt = cnt;
        end
        pending_results.push_back(r);
        clear_packet_state();
    endfunction

    // Prediction follows every transfer accepted on the byte stream.
    always @(posedge i_clk) begin
        if (i_rst_n && s_tvalid && o_s_tready) absorb_byte(s_tdata, s_tlast);
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // Result checker: every accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_m_tvalid && m_tready) begin
            got.kind    = o_m_tuser;
            got.pbyte   = o_m_tdata[7:0];
            got.pidx    = o_m_tdata[12:8];
            got.code    = o_m_tdata[15:13];
            got.id      = o_m_tdata[23:16];
            got.err     = o_m_tdata[31:24];
            got.cnt     = o_m_tdata[39:32];
            got.run_end = o_m_tlast;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result with nothing expected, data %h", o_m_tdata));
            end else begin
                want = pending_results.pop_front();
                if (got.kind != want.kind)
                    report_mismatch($sformatf("result_kind %0d, want %0d", got.kind, want.kind));
                if (got.pbyte != want.pbyte)
                    report_mismatch($sformatf("param_byte %h, want %h", got.pbyte, want.pbyte));
                if (got.pidx != want.pidx)
                    report_mismatch($sformatf("param_index %0d, want %0d", got.pidx, want.pidx));
                if (got.code != want.code)
                    report_mismatch($sformatf("status_code %0d, want %0d", got.code, want.code));
                if (got.id != want.id)
                    report_mismatch($sformatf("device_id %h, want %h", got.id, want.id));
                if (got.err != want.err)
                    report_mismatch($sformatf("device_error %h, want %h", got.err, want.err));
                if (got.cnt != want.cnt)
                    report_mismatch($sformatf("param_count %0d, want %0d", got.cnt, want.cnt));
                if (got.run_end != want.run_end)
                    report_mismatch($sformatf("run_end %0d, want %0d", got.run_end, want.run_end));
            end
        end
    end

    // Receiver: the ready pattern switches at random among four characters; a long
    // hold-off can be laid over it from the pressure test.
    int unsigned rx_tick = 0;
    int unsigned rx_mode = 0;
    always @(posedge i_clk) begin
        rx_tick++;
        if (rx_tick % 97 == 0) rx_mode = $urandom_range(0, 3);
        if (hold_on) begin
            m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= $urandom_range(0, 1);
                2:       m_tready <= ($urandom_range(0, 7) != 0);
                default: m_tready <= (rx_tick % 3 == 0);
            endcase
        end
    end

    always begin
        @(start_hold);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_on <= 1'b0;
    end

    // Watchdog: ends the run when no transfer happens for too long.
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_tvalid && o_s_tready) || (o_m_tvalid && m_tready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Sends one byte; bursts of random length with random gaps in between.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (sender_gaps && burst_left <= 0) begin
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic transmit_packet();
        for (int i = 0; i < pkt_bytes.size(); i++)
            send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
    endtask

    // Builds a framed packet with random reserved byte and parameters, CRC appended.
    function automatic void frame_packet(input logic [7:0] id, input logic [7:0] instr,
                                         input logic [7:0] err, input int nparams,
                                         input logic [15:0] len);
        logic [15:0] crc;
        pkt_bytes = {HDR_SYNC, HDR_SYNC, HDR_LAST, 8'($urandom), id, len[7:0], len[15:8],
                     instr, err};
        for (int i = 0; i < nparams; i++) pkt_bytes.push_back(8'($urandom));
        crc = '0;
        foreach (pkt_bytes[i]) crc = crc16_step(crc, pkt_bytes[i]);
        pkt_bytes.push_back(crc[7:0]);
        pkt_bytes.push_back(crc[15:8]);
    endfunction

    task automatic send_status(input int nparams);
        frame_packet(8'($urandom), INSTR_STAT, 8'($urandom), nparams, 16'(nparams + 4));
        transmit_packet();
    endtask

    // Stops offering bytes and waits until every expected result is in.
    task automatic settle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // APB write of max_params while idle, then a read back.
    task automatic write_max_params(input logic [5:0] value);
        settle();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= REG_MAX_PARAMS;
        pwdata  <= {26'h0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        max_params_cfg = value;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== {26'h0, value})
            report_mismatch($sformatf("max_params read %h, want %h", prdata, value));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Good packets at the reset limit of 32, up to one past the limit.
    task automatic test_good_packets();
        send_status(0);
        send_status(1);
        send_status(5);
        send_status(32);
        send_status(33);  // too many params, id/err/count still reported
    endtask

    // Header, CRC and instruction faults one at a time.
    task automatic test_header_and_crc();
        for (int k = 0; k < 3; k++) begin
            frame_packet(8'h01, INSTR_STAT, 8'h00, 2, 16'd6);
            pkt_bytes[k] = pkt_bytes[k] ^ 8'h02;
            transmit_packet();
        end
        frame_packet(8'hFF, INSTR_STAT, 8'hFF, 3, 16'd7);
        pkt_bytes[pkt_bytes.size() - 2] ^= 8'h80;   // CRC low
        transmit_packet();
        frame_packet(8'h00, INSTR_STAT, 8'h00, 3, 16'd7);
        pkt_bytes[pkt_bytes.size() - 1] ^= 8'h01;   // CRC high
        transmit_packet();
        frame_packet(8'h42, INSTR_STAT, 8'h11, 4, 16'd8);
        pkt_bytes[10] ^= 8'h10;                      // payload hit
        transmit_packet();
        frame_packet(8'h42, 8'h03, 8'h11, 4, 16'd8); // instruction packet, not status
        transmit_packet();
        frame_packet(8'h42, 8'hD5, 8'h11, 0, 16'd4);
        transmit_packet();
    endtask

    // Size limits: short, bad size masking a bad header, longest good,
    // one too long, and one beyond the position counter's saturation.
    task automatic test_packet_size();
        send_byte(8'hFF, 1'b1);
        frame_packet(8'h05, INSTR_STAT, 8'h00, 0, 16'd4);
        void'(pkt_bytes.pop_back());
        transmit_packet();
        frame_packet(8'h05, INSTR_STAT, 8'h00, 0, 16'd4);
        void'(pkt_bytes.pop_back());
        pkt_bytes[0] = 8'h00;
        transmit_packet();
        frame_packet(8'h07, INSTR_STAT, 8'h20, 244, 16'd9);
        transmit_packet();
        frame_packet(8'h07, INSTR_STAT, 8'h20, 245, 16'd9);
        transmit_packet();
        frame_packet(8'h07, INSTR_STAT, 8'h20, 509, 16'd9);
        transmit_packet();
    endtask

    // Length field: high byte ignored, wrap below 4, count past the packet.
    task automatic test_length_field();
        frame_packet(8'h10, INSTR_STAT, 8'h01, 2, 16'h0104);
        transmit_packet();
        frame_packet(8'h11, INSTR_STAT, 8'h02, 1, 16'h0000);
        transmit_packet();
        frame_packet(8'h12, INSTR_STAT, 8'h03, 0, 16'hFF03);
        transmit_packet();
        // claims 10 params, carries 3: CRC bytes show up, the rest read zero
        frame_packet(8'h13, INSTR_STAT, 8'h04, 3, 16'd14);
        transmit_packet();
    endtask

    // Limit register at its extremes and a value above the buffer depth.
    task automatic test_param_limit();
        write_max_params(6'd0);
        send_status(0);
        send_status(1);
        write_max_params(6'd63);
        send_status(32);
        send_status(33);
        write_max_params(6'd1);
        send_status(1);
        send_status(2);
        write_max_params(6'd32);
    endtask

    // Receiver holds off while the sender keeps offering back-to-back packets.
    task automatic test_back_pressure();
        settle();
        sender_gaps = 1'b0;
        -> start_hold;
        for (int i = 0; i < 4; i++) send_status(20);
        settle();
        sender_gaps = 1'b1;
    endtask

    // Mostly well-formed packets with random content; the rest broken or noise.
    task automatic test_random_traffic();
        int start;
        int pkts;
        int lim;
        int np;
        int len;
        start = bytes_sent;
        pkts  = 0;
        while (bytes_sent - start < RANDOM_BYTES) begin
            if (pkts % 7 == 6) write_max_params(6'($urandom_range(0, 63)));
            lim = (int'(max_params_cfg) > MAX_LIMIT) ? MAX_LIMIT : int'(max_params_cfg);
            np  = $urandom_range(0, (lim < 24) ? lim : 24);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    send_status(np);
                end
                6: begin  // single bit error anywhere
                    frame_packet(8'($urandom), INSTR_STAT, 8'($urandom), np, 16'(np + 4));
                    len = $urandom_range(0, pkt_bytes.size() - 1);
                    pkt_bytes[len] ^= 8'(1 << $urandom_range(0, 7));
                    transmit_packet();
                end
                7: begin  // random instruction and length field
                    frame_packet(8'($urandom), 8'($urandom), 8'($urandom), np, 16'($urandom));
                    transmit_packet();
                end
                8: begin  // truncated packet
                    frame_packet(8'($urandom), INSTR_STAT, 8'($urandom), np, 16'(np + 4));
                    len = $urandom_range(1, pkt_bytes.size() - 1);
                    while (pkt_bytes.size() > len) void'(pkt_bytes.pop_back());
                    transmit_packet();
                end
                default: begin  // line noise
                    len = $urandom_range(1, 20);
                    pkt_bytes.delete();
                    repeat (len) pkt_bytes.push_back(8'($urandom));
                    transmit_packet();
                end
            endcase
            pkts++;
        end
    endtask

    initial begin
        clear_packet_state();
        foreach (pbuf[i]) pbuf[i] = '0;
        max_params_cfg = 6'd32;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_good_packets();
        test_header_and_crc();
        test_packet_size();
        test_length_field();
        test_param_limit();
        test_back_pressure();
        test_random_traffic();

        settle();
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
